### rtl/base64url_unpadded_decoder_defines.svh
// ----------------------------------------------------------------------------
// base64url_unpadded_decoder_defines
// Assertion macros for the URL-safe base64 decoder; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BASE64URL_UNPADDED_DECODER_DEFINES_SVH
`define BASE64URL_UNPADDED_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, switched off while reset is high
`define B64U_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64u: implication check failed");
// next-cycle implication, live through reset
`define B64U_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("b64u: next-cycle check failed");
`else
`define B64U_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define B64U_ASSERT_NXT(lbl, clk, ante, cons)
`endif

`endif

### rtl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the alphabet lookup for the base64url decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64u_pkg;

  localparam int unsigned POS_BITS_DEF = 32;
  localparam int unsigned OUT_POS_W    = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SEXTET_W     = 6;
  localparam int unsigned M_TDATA_W    = BYTE_W + OUT_POS_W;

  localparam logic [7:0] NOT_IN_ALPHABET = 8'd255;
  localparam logic [1:0] GROUP_LAST_SLOT = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_CHR = 2'd1,
    STAT_BAD_LEN = 2'd2
  } b64u_status_t;

  // results produced by one character, handed to the output buffer
  typedef struct packed {
    logic [1:0]            n;
    logic [BYTE_W-1:0]     b0;
    logic [BYTE_W-1:0]     b1;
    logic [BYTE_W-1:0]     b2;
    logic                  last;
    b64u_status_t          status;
    logic [OUT_POS_W-1:0]  pos;
  } b64u_grp_t;

  // character to sextet; NOT_IN_ALPHABET outside A-Z a-z 0-9 - _
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    begin
      if (c >= 8'h41 && c <= 8'h5A)      v = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
      else if (c == 8'h2D)               v = 8'd62;
      else if (c == 8'h5F)               v = 8'd63;
      else                               v = NOT_IN_ALPHABET;
      return v;
    end
  endfunction

endpackage

### rtl/b64u_out_buf.sv
// ----------------------------------------------------------------------------
// b64u_out_buf
// Holds the results of one character and hands them out one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64u_out_buf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  b64u_pkg::b64u_grp_t           grp,
  output logic                          can_load,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [b64u_pkg::M_TDATA_W-1:0] m_tdata,  // byte_out, bad_position
  output logic                          m_tlast,
  output logic [1:0]                    m_tuser    // status
);
  import b64u_pkg::*;

  b64u_grp_t         grp_q;
  logic              valid;
  logic [1:0]        idx;
  logic [1:0]        last_idx;
  logic              at_end;
  logic [BYTE_W-1:0] cur_byte;

  assign last_idx = grp_q.n - 2'd1;
  assign at_end   = (idx == last_idx);
  assign can_load = !valid || (m_tready && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (valid && m_tready) begin
      if (at_end) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_q <= grp;
    end
  end

  always_comb begin
    case (idx)
      2'd0:    cur_byte = grp_q.b0;
      2'd1:    cur_byte = grp_q.b1;
      2'd2:    cur_byte = grp_q.b2;
      default: cur_byte = '0;
    endcase
  end

  assign m_tvalid = valid;
  assign m_tdata  = {grp_q.pos, cur_byte};
  assign m_tlast  = grp_q.last && at_end;
  assign m_tuser  = grp_q.status;

endmodule

### rtl/base64url_unpadded_decoder.sv
// ----------------------------------------------------------------------------
// base64url_unpadded_decoder
// URL-safe base64 decoder without padding, one character per transaction in,
// one decoded byte (or one error report) per transaction out.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                           | tlast        | tuser
//  --------+-----+---------------------------------+--------------+--------
//  s_      | in  | [7:0] char_in                   | is_last      | -
//  m_      | out | [7:0] byte_out, [39:8] bad_pos  | last_out     | status
//
//  A character is registered on acceptance and decoded in the next cycle
//  against the group state; its results (none, one, two or three) load a
//  small output buffer that drains one per cycle while m_tready is high.
//  The first result is offered from the buffer once the held character advances.
//  Characters that give no result pass without waiting on the buffer, so
//  a steady stream runs at one character per cycle while m_tready is high;
//  a group's three bytes drain while the next group's first three are taken.
//  Input stalls when a result-bearing character meets a buffer that is
//  still draining: while m_tready is low, and also with m_tready high when
//  a string closes with a tail of one or two characters straight after a
//  full group, before that group's three bytes have drained.
//  Synchronous reset clears the group state, character count, drop flag and
//  both valid flags; no clearing pass.
//
`timescale 1ns / 1ps
`include "base64url_unpadded_decoder_defines.svh"

module base64url_unpadded_decoder #(
  parameter int unsigned POS_BITS = b64u_pkg::POS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // char_in
  input  logic                           s_tlast,   // is_last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [b64u_pkg::M_TDATA_W-1:0] m_tdata,   // byte_out, bad_position
  output logic                           m_tlast,   // last_out
  output logic [1:0]                     m_tuser    // status
);
  import b64u_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // decoder state
  logic [1:0]          group_count, group_count_next;
  logic [17:0]         sextet_acc,  sextet_acc_next;
  logic [POS_BITS-1:0] char_count,  char_count_next;
  logic                group_bad,   group_bad_next;
  logic                dropping,    dropping_next;

  logic [7:0]          v_raw;
  logic                inval;
  logic [5:0]          v;
  logic                bad;
  logic [POS_BITS-1:0] start;
  logic [5:0]          s1, s2, s3;
  b64u_grp_t           grp;
  logic                can_load;
  logic                advance;
  logic                s_hs;

  assign s_hs = s_tvalid && s_tready;

  assign v_raw = sextet_of(in_char);
  assign inval = (v_raw == NOT_IN_ALPHABET);
  assign v     = inval ? 6'd0 : v_raw[5:0];
  assign bad   = group_bad || inval;
  assign start = char_count - POS_BITS'(group_count);
  assign s1    = sextet_acc[17:12];
  assign s2    = sextet_acc[11:6];
  assign s3    = sextet_acc[5:0];

  // decode of the held character against the current group
  always_comb begin
    group_count_next = group_count;
    sextet_acc_next  = sextet_acc;
    char_count_next  = char_count;
    group_bad_next   = group_bad;
    dropping_next    = dropping;
    grp              = '0;
    grp.status       = STAT_OK;

    if (dropping) begin
      // skip to the end of the string
      if (in_last) begin
        dropping_next   = 1'b0;
        char_count_next = '0;
      end
    end else if (group_count == GROUP_LAST_SLOT) begin
      if (bad) begin
        grp.n      = 2'd1;
        grp.last   = 1'b1;
        grp.status = STAT_BAD_CHR;
        grp.pos    = OUT_POS_W'(start);
        dropping_next = !in_last;
      end else begin
        grp.n    = 2'd3;
        grp.b0   = {s1, s2[5:4]};
        grp.b1   = {s2[3:0], s3[5:2]};
        grp.b2   = {s3[1:0], v};
        grp.last = in_last;
      end
      group_count_next = '0;
      sextet_acc_next  = '0;
      group_bad_next   = 1'b0;
      char_count_next  = in_last ? '0 : char_count + POS_BITS'(1);
    end else if (in_last) begin
      grp.n    = 2'd1;
      grp.last = 1'b1;
      if (group_count == 2'd0) begin
        // a lone final character can never form a byte
        grp.status = STAT_BAD_LEN;
        grp.pos    = OUT_POS_W'(start);
      end else if (bad) begin
        grp.status = STAT_BAD_CHR;
        grp.pos    = OUT_POS_W'(start);
      end else if (group_count == 2'd1) begin
        grp.b0 = {s3, v[5:4]};
      end else begin
        grp.n    = 2'd2;
        grp.b0   = {s2, s3[5:4]};
        grp.b1   = {s3[3:0], v[5:2]};
      end
      group_count_next = '0;
      sextet_acc_next  = '0;
      group_bad_next   = 1'b0;
      char_count_next  = '0;
    end else begin
      sextet_acc_next  = {sextet_acc[11:0], v};
      group_bad_next   = bad;
      group_count_next = group_count + 2'd1;
      char_count_next  = char_count + POS_BITS'(1);
    end
  end

  // result-free characters never wait on the output buffer
  assign advance  = in_valid && ((grp.n == 2'd0) || can_load);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_hs) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      sextet_acc  <= '0;
      char_count  <= '0;
      group_bad   <= 1'b0;
      dropping    <= 1'b0;
    end else if (advance) begin
      group_count <= group_count_next;
      sextet_acc  <= sextet_acc_next;
      char_count  <= char_count_next;
      group_bad   <= group_bad_next;
      dropping    <= dropping_next;
    end
  end

  b64u_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (grp.n != 2'd0)),
    .grp      (grp),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // error reports always close the string
  `B64U_ASSERT_IMP(a_err_is_last, clk, rst, m_tvalid && (m_tuser != STAT_OK), m_tlast)
  // ok bytes carry no offset
  `B64U_ASSERT_IMP(a_ok_no_pos, clk, rst, m_tvalid && (m_tuser == STAT_OK), m_tdata[M_TDATA_W-1:BYTE_W] == '0)
  // a dropped string leaves no group half built
  `B64U_ASSERT_IMP(a_drop_clean, clk, rst, dropping, (group_count == 2'd0) && !group_bad)
  // nothing offered right after reset
  `B64U_ASSERT_NXT(a_rst_quiet, clk, rst, !m_tvalid && !in_valid)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the URL-safe base64 decoder: streams characters in,
// predicts every decoded byte and error report, and compares each output
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import b64u_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no transaction
  localparam int unsigned DRAIN_WAIT  = 20;    // cycles after the last result
  localparam int unsigned RAND_ITEMS  = 240;

  // one predicted output transaction
  typedef struct packed {
    logic [BYTE_W-1:0]    byte_val;
    logic                 is_final;
    b64u_status_t         status;
    logic [OUT_POS_W-1:0] pos;
  } decoded_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata  = 8'd0;   // char_in
  logic                 s_tlast  = 1'b0;   // is_last
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;           // [7:0] byte_out, [39:8] bad_position
  logic                 m_tlast;           // last_out
  logic [1:0]           m_tuser;           // status

  // predictor state: mirrors the decoder's group and string bookkeeping
  logic [1:0]           grp_fill;
  logic [17:0]          grp_sextets;
  logic [31:0]          chars_taken;
  logic                 grp_has_bad;
  logic                 skip_to_end;

  decoded_t             decoded_q[$];

  int unsigned          tx_idle_pct = 29;
  int unsigned          rx_stall_pct = 29;
  int unsigned          quiet_cycles = 0;
  int unsigned          mismatches = 0;
  int unsigned          live_chars = 0;
  int unsigned          strings_sent = 0;
  int unsigned          bytes_checked = 0;
  int unsigned          bad_chr_seen = 0;
  int unsigned          bad_len_seen = 0;

  base64url_unpadded_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // alphabet lookup; NOT_IN_ALPHABET for anything outside A-Z a-z 0-9 - _
  function automatic logic [7:0] char_to_sextet(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) return c - 8'h41;
    if (c inside {[8'h61:8'h7A]}) return c - 8'h61 + 8'd26;
    if (c inside {[8'h30:8'h39]}) return c - 8'h30 + 8'd52;
    if (c == 8'h2D) return 8'd62;
    if (c == 8'h5F) return 8'd63;
    return NOT_IN_ALPHABET;
  endfunction

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + v;
    if (v < 6'd52) return 8'h61 + (v - 6'd26);
    if (v < 6'd62) return 8'h30 + (v - 6'd52);
    if (v == 6'd62) return 8'h2D;
    return 8'h5F;
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (char_to_sextet(c) != NOT_IN_ALPHABET) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic expect_result(input logic [7:0] b, input logic fin,
                               input b64u_status_t st, input logic [31:0] pos);
    decoded_t r;
    r.byte_val = b;
    r.is_final = fin;
    r.status   = st;
    r.pos      = pos;
    decoded_q.push_back(r);
  endtask

  task automatic clear_string();
    grp_fill    = 2'd0;
    grp_sextets = 18'd0;
    grp_has_bad = 1'b0;
    chars_taken = 32'd0;
    skip_to_end = 1'b0;
  endtask

  // works out what one accepted character produces and updates the state
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [7:0]  v;
    logic        bad;
    logic [31:0] grp_start;
    logic [5:0]  s1, s2, s3;
    if (skip_to_end) begin
      // error already reported: swallow characters up to the end of string
      if (fin) clear_string();
    end else begin
      v   = char_to_sextet(c);
      bad = grp_has_bad || (v == NOT_IN_ALPHABET);
      if (v == NOT_IN_ALPHABET) v = 8'd0;
      grp_start = chars_taken - 32'(grp_fill);
      s1 = grp_sextets[17:12];
      s2 = grp_sextets[11:6];
      s3 = grp_sextets[5:0];
      if (grp_fill == GROUP_LAST_SLOT) begin
        // fourth character closes the group: three bytes or one error
        if (bad) begin
          expect_result(8'd0, 1'b1, STAT_BAD_CHR, grp_start);
          skip_to_end = !fin;
        end else begin
          expect_result({s1, s2[5:4]}, 1'b0, STAT_OK, 32'd0);
          expect_result({s2[3:0], s3[5:2]}, 1'b0, STAT_OK, 32'd0);
          expect_result({s3[1:0], v[5:0]}, fin, STAT_OK, 32'd0);
        end
        grp_fill    = 2'd0;
        grp_sextets = 18'd0;
        grp_has_bad = 1'b0;
        chars_taken = chars_taken + 32'd1;
        if (fin) clear_string();
      end else if (fin) begin
        // short tail at end of string
        if (grp_fill == 2'd0)
          expect_result(8'd0, 1'b1, STAT_BAD_LEN, grp_start);
        else if (bad)
          expect_result(8'd0, 1'b1, STAT_BAD_CHR, grp_start);
        else if (grp_fill == 2'd1)
          expect_result({s3, v[5:4]}, 1'b1, STAT_OK, 32'd0);
        else begin
          expect_result({s2, s3[5:4]}, 1'b0, STAT_OK, 32'd0);
          expect_result({s3[3:0], v[5:2]}, 1'b1, STAT_OK, 32'd0);
        end
        clear_string();
      end else begin
        grp_sextets = {grp_sextets[11:0], v[5:0]};
        grp_has_bad = bad;
        grp_fill    = grp_fill + 2'd1;
        chars_taken = chars_taken + 32'd1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // one input transaction; s_tvalid stays high into the next call unless it
  // decides to idle, so it is never dropped and raised in the same step
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!skip_to_end) live_chars++;
    if (fin) strings_sent++;
    decode_char(c, fin);
  endtask

  // sends a text; is_last on its final character only when close is set
  task automatic send_text(input string txt, input bit close);
    for (int i = 0; i < txt.len(); i++)
      send_char(txt[i], close && (i == txt.len() - 1));
  endtask

  // alphabet boundaries in two full groups
  task automatic test_alphabet_edges();
    send_text("AZaz09-_", 1'b1);
  endtask

  // tails of two and three, and a lone valid character (bad length)
  task automatic test_tail_lengths();
    send_text("AB", 1'b1);
    send_text("___", 1'b1);
    send_text("Q", 1'b1);
  endtask

  // bad character opening a group, then everything up to is_last dropped
  task automatic test_drop_after_error();
    send_text("[AAA`:/", 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // bad character in a tail, and a lone out-of-alphabet byte
  task automatic test_bad_tails();
    send_text("x{", 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // mostly well-formed strings of random content, some with one bad
  // character, a few made of raw bytes
  task automatic test_random_strings();
    int unsigned start_count;
    int unsigned len;
    int unsigned kind;
    int unsigned bad_at;
    logic [7:0]  c;
    start_count = live_chars;
    while (live_chars - start_count < RAND_ITEMS) begin
      // a stretch with no idling on either side in the middle third
      if (live_chars - start_count inside {[RAND_ITEMS / 3 : 2 * RAND_ITEMS / 3]}) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct  = 29;
        rx_stall_pct = 29;
      end
      len    = $urandom_range(1, 13);
      kind   = $urandom_range(99);
      bad_at = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
        if (kind < 5)
          c = 8'($urandom_range(255));
        else if (kind < 20 && i == bad_at)
          c = random_bad_char();
        else
          c = sextet_to_char(6'($urandom_range(63)));
        send_char(c, i == len - 1);
      end
    end
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
  endtask

  // --------------------------------------------------------------------------
  // Checking: every output transaction against the oldest prediction
  // --------------------------------------------------------------------------

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: byte_out %02h last_out %0d status %0d",
             m_tdata[7:0], m_tlast, m_tuser);
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      bytes_checked++;
      if (want.status == STAT_BAD_CHR) bad_chr_seen++;
      if (want.status == STAT_BAD_LEN) bad_len_seen++;
      if (m_tdata[BYTE_W-1:0] !== want.byte_val) begin
        $error("byte_out: expected %02h, got %02h", want.byte_val, m_tdata[BYTE_W-1:0]);
        mismatches++;
      end
      if (m_tlast !== want.is_final) begin
        $error("last_out: expected %0d, got %0d", want.is_final, m_tlast);
        mismatches++;
      end
      if (m_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_tuser);
        mismatches++;
      end
      if (m_tdata[M_TDATA_W-1:BYTE_W] !== want.pos) begin
        $error("bad_position: expected %0d, got %0d", want.pos,
               m_tdata[M_TDATA_W-1:BYTE_W]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: a run of cycles with no transaction on either side is a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_string();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_alphabet_edges();
    test_tail_lengths();
    test_drop_after_error();
    test_bad_tails();
    test_random_strings();

    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // anything arriving now has no prediction and is flagged by the checker
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Decoded %0d strings from %0d live characters.", strings_sent, live_chars);
    $display("Checked %0d output transactions: %0d bad-character, %0d bad-length.",
             bytes_checked, bad_chr_seen, bad_len_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/b64u_pkg.sv
rtl/b64u_out_buf.sv
rtl/base64url_unpadded_decoder.sv
tb/testbench.sv
